// ===== hdl/mthd_pkg.sv =====
// Package for the median-threshold hit detector.
// Holds the widths, rank constants, register indexes and payload types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package mthd_pkg;

  localparam int unsigned CHANNELS     = 10;
  localparam int unsigned POWER_WIDTH  = 32;
  localparam int unsigned COUNT_WIDTH  = 16;
  localparam int unsigned FACTOR_WIDTH = 16;
  localparam int unsigned PROD_WIDTH   = POWER_WIDTH + FACTOR_WIDTH;
  localparam int unsigned CH_IDX_W     = $clog2(CHANNELS);
  localparam int unsigned RANK_W       = $clog2(CHANNELS);
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [RANK_W-1:0]       MEDIAN_RANK  = RANK_W'(5);
  localparam logic [RANK_W-1:0]       MAX_RANK     = RANK_W'(CHANNELS - 1);
  localparam logic [FACTOR_WIDTH-1:0] FACTOR_RESET = FACTOR_WIDTH'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR     = 2'd0,
    CFG_MASK       = 2'd1,
    CFG_IGNORE_ALL = 2'd2
  } cfg_idx_e;

  typedef logic [POWER_WIDTH-1:0] power_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef power_t [CHANNELS-1:0] power_vec_t;
  typedef logic [CHANNELS-1:0][RANK_W-1:0] rank_vec_t;
  typedef count_t [CHANNELS-1:0] count_vec_t;

  typedef struct packed {
    power_t power_ch0;
    power_t power_ch1;
    power_t power_ch2;
    power_t power_ch3;
    power_t power_ch4;
    power_t power_ch5;
    power_t power_ch6;
    power_t power_ch7;
    power_t power_ch8;
    power_t power_ch9;
    logic   lockout_active;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [CH_IDX_W-1:0] last_channel;
    count_t              hit_count;
    power_t              median_power;
  } out_item_t;

  typedef struct packed {
    logic rank_en;
    logic count_inc;
  } lane_ctrl_t;

  typedef struct packed {
    power_t              median;
    power_t              max_power;
    logic [CH_IDX_W-1:0] top;
  } merge_t;

endpackage

// ===== hdl/mthd_lane.sv =====
// One channel lane: computes the stable ascending rank of its channel
// and holds that channel's saturating hit counter. Uses mthd_pkg.
`timescale 1ns / 1ps

module mthd_lane import mthd_pkg::*; #(
  parameter int unsigned LANE_ID = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  power_vec_t        power_i,
  output logic [RANK_W-1:0] rank_o,
  output count_t            count_o
);

  logic [RANK_W-1:0] rank_d, rank_q;
  count_t            count_q;

  always_comb begin
    rank_d = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (power_i[k] < power_i[LANE_ID] ||
          (power_i[k] == power_i[LANE_ID] && k < LANE_ID)) begin
        rank_d = rank_d + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rank_en) begin
      rank_q <= rank_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.count_inc && count_q != '1) begin
      count_q <= count_q + COUNT_WIDTH'(1);
    end
  end

  assign rank_o  = rank_q;
  assign count_o = count_q;

endmodule

// ===== hdl/mthd_merge.sv =====
// Merge stage: picks the median and the maximum channel from the lane ranks.
// Uses mthd_pkg; fed by the mthd_lane instances.
`timescale 1ns / 1ps

module mthd_merge import mthd_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  rank_vec_t  rank_i,
  input  power_vec_t power_i,
  output merge_t     merge_o
);

  merge_t merge_d, merge_q;

  always_comb begin
    merge_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (rank_i[c] == MEDIAN_RANK) begin
        merge_d.median = merge_d.median | power_i[c];
      end
      if (rank_i[c] == MAX_RANK) begin
        merge_d.max_power = merge_d.max_power | power_i[c];
        merge_d.top       = merge_d.top | CH_IDX_W'(c);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

// ===== hdl/median_threshold_hit_detector.sv =====
// Median-threshold hit detector top level: input capture, ten rank lanes,
// merge, threshold multiply and decision. Uses mthd_pkg, mthd_lane, mthd_merge.
// Each item walks through the rank, merge, multiply and decide steps in turn,
// and a new transaction is accepted only after the previous one leaves the
// decide step, which a stalled output holds.
// Reset: asynchronous, clears hit counts, last channel and registers to defaults.
`timescale 1ns / 1ps

module median_threshold_hit_detector import mthd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_MERGE,
    S_MULT,
    S_DECIDE
  } state_e;

  state_e                  state_q;
  logic [FACTOR_WIDTH-1:0] factor_q;
  logic [CHANNELS-1:0]     mask_q;
  logic                    ignore_all_q;
  power_vec_t              power_q;
  logic                    skip_q;
  logic [PROD_WIDTH-1:0]   prod_q;
  logic [CH_IDX_W-1:0]     recent_q, recent_d;
  count_t                  recent_count_q, recent_count_d;
  out_item_t               out_q, out_d;
  logic                    out_valid_q;

  rank_vec_t  lane_rank;
  count_vec_t lane_count;
  lane_ctrl_t lane_ctrl [CHANNELS];
  merge_t     merge;

  logic   in_fire, decide_fire, pass, hit;
  count_t top_count;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign decide_fire = (state_q == S_DECIDE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q     <= FACTOR_RESET;
      mask_q       <= '0;
      ignore_all_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FACTOR:     factor_q     <= cfg_wdata_i[FACTOR_WIDTH-1:0];
        CFG_MASK:       mask_q       <= cfg_wdata_i[CHANNELS-1:0];
        CFG_IGNORE_ALL: ignore_all_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      power_q[0] <= in_data_i.power_ch0;
      power_q[1] <= in_data_i.power_ch1;
      power_q[2] <= in_data_i.power_ch2;
      power_q[3] <= in_data_i.power_ch3;
      power_q[4] <= in_data_i.power_ch4;
      power_q[5] <= in_data_i.power_ch5;
      power_q[6] <= in_data_i.power_ch6;
      power_q[7] <= in_data_i.power_ch7;
      power_q[8] <= in_data_i.power_ch8;
      power_q[9] <= in_data_i.power_ch9;
      skip_q     <= in_data_i.lockout_active || ignore_all_q;
    end
    if (state_q == S_MULT) begin
      prod_q <= PROD_WIDTH'(merge.median) * PROD_WIDTH'(factor_q);
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    assign lane_ctrl[c].rank_en   = (state_q == S_RANK);
    assign lane_ctrl[c].count_inc = decide_fire && hit && (merge.top == CH_IDX_W'(c));

    mthd_lane #(
      .LANE_ID(c)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl[c]),
      .power_i(power_q),
      .rank_o (lane_rank[c]),
      .count_o(lane_count[c])
    );
  end

  mthd_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (state_q == S_MERGE),
    .rank_i (lane_rank),
    .power_i(power_q),
    .merge_o(merge)
  );

  always_comb begin
    top_count = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (merge.top == CH_IDX_W'(c)) begin
        top_count = lane_count[c];
      end
    end
    pass           = !skip_q && (PROD_WIDTH'(merge.max_power) > prod_q);
    hit            = pass && !mask_q[merge.top];
    recent_d       = pass ? merge.top : recent_q;
    recent_count_d = recent_count_q;
    if (pass) begin
      recent_count_d = top_count;
      if (hit && top_count != '1) begin
        recent_count_d = top_count + COUNT_WIDTH'(1);
      end
    end
    out_d.hit          = hit;
    out_d.last_channel = recent_d;
    out_d.hit_count    = recent_count_d;
    out_d.median_power = skip_q ? '0 : merge.median;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      recent_q       <= '0;
      recent_count_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_RANK;
          end
        end
        S_RANK:  state_q <= S_MERGE;
        S_MERGE: state_q <= S_MULT;
        S_MULT:  state_q <= S_DECIDE;
        S_DECIDE: begin
          if (decide_fire) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (decide_fire) begin
        recent_q       <= recent_d;
        recent_count_q <= recent_count_d;
        out_valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (decide_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  a_hit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_count != '0)
    else $error("hit reported with a zero count");

  a_hit_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.last_channel < CH_IDX_W'(CHANNELS))
    else $error("hit reported on a channel out of range");

  a_skip_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    decide_fire && skip_q |=> out_valid_o && !out_data_o.hit &&
      out_data_o.median_power == '0)
    else $error("skipped set produced a hit or a median");
`endif

endmodule

// ===== bench/median_threshold_hit_detector_test.sv =====
// Self-checking testbench for the median-threshold hit detector.
// It runs a directed table and random register phases and checks every result
// against pinned values or an in-bench predictor; uses mthd_pkg and the DUT.
`timescale 1ns / 1ps

module median_threshold_hit_detector_test;
  import mthd_pkg::*;

  localparam int unsigned CYCLE_LIMIT        = 2_000_000;
  localparam int unsigned RESET_CYCLES       = 8;
  localparam int unsigned SETTLE_CYCLES      = 8;
  localparam int unsigned LONG_HOLD_CYCLES   = 300;
  localparam int unsigned MAX_PRINTED        = 40;
  localparam int unsigned RANDOM_PHASES      = 6;
  localparam int unsigned PHASE_SETS         = 100;
  localparam int unsigned SHORT_PHASE_SETS   = 30;
  localparam int unsigned IGNORE_PHASE       = 4;
  localparam int unsigned PRESSURE_PHASE     = 5;
  localparam int unsigned FIRST_POWER_BIT    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic {
    ROW_SET,
    ROW_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_data;
    in_item_t                 item;
    logic                     pinned;
    out_item_t                result;
  } stim_row_t;

  typedef struct packed {
    logic      pinned;
    out_item_t result;
  } fixed_report_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_FACTOR;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  logic [FACTOR_WIDTH-1:0] pred_factor     = FACTOR_RESET;
  logic [CHANNELS-1:0]     pred_mask       = '0;
  logic                    pred_ignore_all = 1'b0;
  logic [CH_IDX_W-1:0]     pred_recent     = '0;
  count_t                  pred_counts [CHANNELS] = '{default: '0};

  out_item_t     hit_reports[$];
  fixed_report_t fixed_reports[$];
  stim_row_t     directed_rows[$];

  logic        steady_flow   = 1'b0;
  logic        long_hold_req = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned hits_seen     = 0;
  int unsigned sets_accepted = 0;
  int unsigned locked_sets   = 0;
  int unsigned reg_writes    = 0;

  median_threshold_hit_detector dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               hit_reports.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic power_t power_of(in_item_t s, int unsigned c);
    return s[FIRST_POWER_BIT + (CHANNELS - 1 - c) * POWER_WIDTH +: POWER_WIDTH];
  endfunction

  function automatic in_item_t with_power(in_item_t s, int unsigned c, power_t v);
    s[FIRST_POWER_BIT + (CHANNELS - 1 - c) * POWER_WIDTH +: POWER_WIDTH] = v;
    return s;
  endfunction

  function automatic in_item_t flat_set(power_t v, logic lock);
    in_item_t s;
    s = '0;
    for (int unsigned c = 0; c < CHANNELS; c++) s = with_power(s, c, v);
    s.lockout_active = lock;
    return s;
  endfunction

  function automatic in_item_t peak_set(power_t base, int unsigned ch, power_t peak);
    return with_power(flat_set(base, 1'b0), ch, peak);
  endfunction

  function automatic out_item_t report_of(logic hit, int unsigned ch, count_t cnt, power_t med);
    out_item_t r;
    r.hit          = hit;
    r.last_channel = CH_IDX_W'(ch);
    r.hit_count    = cnt;
    r.median_power = med;
    return r;
  endfunction

  // Unless locked out or ignored, ranks the channels in stable ascending order,
  // then applies threshold, mask and saturating count update to the predictor.
  task automatic judge_power_set(input in_item_t s, output out_item_t res);
    power_t                p [CHANNELS];
    power_t                median_v;
    int unsigned           top_ch;
    int unsigned           rank;
    logic [PROD_WIDTH-1:0] limit;
    logic [PROD_WIDTH-1:0] peak;
    median_v = '0;
    top_ch   = 0;
    res.hit  = 1'b0;
    for (int unsigned c = 0; c < CHANNELS; c++) p[c] = power_of(s, c);
    if (!s.lockout_active && !pred_ignore_all) begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        rank = 0;
        for (int unsigned k = 0; k < CHANNELS; k++) begin
          if (p[k] < p[c] || (p[k] == p[c] && k < c)) rank++;
        end
        if (rank == MEDIAN_RANK) median_v = p[c];
        if (rank == MAX_RANK) top_ch = c;
      end
      limit = PROD_WIDTH'(median_v);
      limit = limit * pred_factor;
      peak  = PROD_WIDTH'(p[top_ch]);
      if (peak > limit) begin
        pred_recent = CH_IDX_W'(top_ch);
        if (!pred_mask[top_ch]) begin
          res.hit = 1'b1;
          if (pred_counts[top_ch] != '1) pred_counts[top_ch] = pred_counts[top_ch] + 1'b1;
        end
      end
    end
    res.last_channel = pred_recent;
    res.hit_count    = pred_counts[pred_recent];
    res.median_power = median_v;
  endtask

  task automatic report_mismatch(string field, logic [POWER_WIDTH-1:0] got,
                                 logic [POWER_WIDTH-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("Mismatch on %s at result %0d: got %0h, expected %0h", field, results_seen, got,
               want);
  endtask

  always @(posedge clk) begin : monitor
    out_item_t     want;
    out_item_t     predicted;
    fixed_report_t pin;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (hit_reports.size() == 0) begin
          report_mismatch("unexpected transaction", out_data.median_power, '0);
        end else begin
          want = hit_reports.pop_front();
          if (out_data.hit !== want.hit) report_mismatch("hit", out_data.hit, want.hit);
          if (out_data.last_channel !== want.last_channel)
            report_mismatch("last_channel", out_data.last_channel, want.last_channel);
          if (out_data.hit_count !== want.hit_count)
            report_mismatch("hit_count", out_data.hit_count, want.hit_count);
          if (out_data.median_power !== want.median_power)
            report_mismatch("median_power", out_data.median_power, want.median_power);
        end
        if (out_data.hit === 1'b1) hits_seen++;
        results_seen++;
      end
      if (in_valid && in_ready) begin
        pin = fixed_reports.pop_front();
        judge_power_set(in_data, predicted);
        hit_reports.push_back(pin.pinned ? pin.result : predicted);
        sets_accepted++;
        if (in_data.lockout_active) locked_sets++;
      end
    end
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 9);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady_flow || $urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req <= 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 20) begin
        stall_left = idle_length();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic in_item_t random_set();
    in_item_t    s;
    int unsigned shape;
    int unsigned shift;
    int unsigned j;
    int unsigned tmp;
    int unsigned order [CHANNELS];
    power_t      peak;
    power_t      m;
    power_t      palette [3];
    logic [63:0] target;
    s     = '0;
    shape = $urandom_range(0, 99);
    if (shape < 35) begin
      shift = $urandom_range(8, 31);
      for (int unsigned c = 0; c < CHANNELS; c++) s = with_power(s, c, $urandom >> shift);
      peak = $urandom | 32'h8000_0000;
      s    = with_power(s, $urandom_range(0, CHANNELS - 1), peak);
      if ($urandom_range(0, 3) == 0) s = with_power(s, $urandom_range(0, CHANNELS - 1), peak);
    end else if (shape < 55) begin
      for (int unsigned c = 0; c < CHANNELS; c++) s = with_power(s, c, $urandom);
    end else if (shape < 75) begin
      // Four copies of the median and five values <= m put m at the sixth place;
      // the peak lands just around m times the factor.
      for (int unsigned c = 0; c < CHANNELS; c++) order[c] = c;
      for (int unsigned c = CHANNELS - 1; c > 0; c--) begin
        j        = $urandom_range(0, c);
        tmp      = order[c];
        order[c] = order[j];
        order[j] = tmp;
      end
      m      = $urandom_range(1, 65536);
      target = 64'(m);
      target = target * pred_factor;
      j      = $urandom_range(0, 2);
      if (j == 0) target = target - 1;
      if (j == 2) target = target + 1;
      if (target < m) target = m;
      if (target > 64'hFFFF_FFFF) target = 64'hFFFF_FFFF;
      s = with_power(s, order[0], target[POWER_WIDTH-1:0]);
      for (int unsigned c = 1; c < 5; c++) s = with_power(s, order[c], m);
      for (int unsigned c = 5; c < CHANNELS; c++) s = with_power(s, order[c], $urandom_range(0, m));
    end else if (shape < 90) begin
      palette[0] = '0;
      palette[1] = '1;
      palette[2] = $urandom;
      for (int unsigned c = 0; c < CHANNELS; c++) s = with_power(s, c, palette[$urandom_range(0, 2)]);
    end else begin
      s = flat_set($urandom, 1'b0);
    end
    s.lockout_active = ($urandom_range(0, 9) == 0);
    return s;
  endfunction

  task automatic send_set(in_item_t s, logic pinned, out_item_t r, int unsigned gap);
    fixed_reports.push_back('{pinned: pinned, result: r});
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    if (in_valid) in_valid <= 1'b0;
    @(posedge clk);
    while (hit_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FACTOR:     pred_factor = data;
      CFG_MASK:       pred_mask = data[CHANNELS-1:0];
      CFG_IGNORE_ALL: pred_ignore_all = data[0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic add_set(in_item_t s, logic pinned = 1'b0, out_item_t r = '0);
    directed_rows.push_back('{kind: ROW_SET, reg_idx: CFG_FACTOR, reg_data: '0, item: s,
                              pinned: pinned, result: r});
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    directed_rows.push_back('{kind: ROW_WRITE, reg_idx: idx, reg_data: data, item: '0,
                              pinned: 1'b0, result: '0});
  endtask

  initial begin : stimulus
    int unsigned phase_sets;
    logic        burst;
    in_item_t    s;

    add_set(flat_set('0, 1'b0), 1'b1, report_of(1'b0, 0, 0, '0));
    add_set(flat_set('1, 1'b0), 1'b1, report_of(1'b0, 0, 0, '1));
    add_set(flat_set('1, 1'b1), 1'b1, report_of(1'b0, 0, 0, '0));
    add_set(peak_set(1, 3, '1), 1'b1, report_of(1'b1, 3, 1, 1));
    add_set(with_power(peak_set('0, 2, 32'h8000_0000), 8, 32'h8000_0000), 1'b1,
            report_of(1'b1, 8, 1, '0));
    s = peak_set(1, 5, '1);
    s.lockout_active = 1'b1;
    add_set(s, 1'b1, report_of(1'b0, 8, 1, '0));
    add_set(peak_set(32'h0001_0000, 4, 32'h0064_0000), 1'b1,
            report_of(1'b0, 8, 1, 32'h0001_0000));
    add_set(peak_set(32'h0001_0000, 4, 32'h0064_0001), 1'b1,
            report_of(1'b1, 4, 1, 32'h0001_0000));
    add_set(with_power(peak_set(32'd5, 0, '0), CHANNELS - 1, 32'd900));
    add_set(peak_set(32'h4000_0000, 6, '1));
    add_write(CFG_FACTOR, 16'd1);
    add_set(peak_set(32'hFFFF_FFFE, 0, '1));
    add_set(flat_set('1, 1'b0));
    add_write(CFG_MASK, 16'hFFFF);
    add_set(peak_set(1, 3, '1));
    add_write(CFG_MASK, 16'h0008);
    add_set(peak_set(1, 5, '1));
    add_set(peak_set(1, 3, '1));
    add_write(CFG_IGNORE_ALL, 16'h0001);
    add_set(peak_set(1, 2, '1));
    add_write(CFG_IGNORE_ALL, 16'h0002);
    add_set(peak_set(1, 2, '1));
    add_write(CFG_SPARE, 16'h0000);
    add_set(flat_set('1, 1'b0));
    add_write(CFG_FACTOR, 16'd0);
    add_set(flat_set(32'h1234_5678, 1'b0));
    add_set(flat_set('0, 1'b0));
    add_write(CFG_FACTOR, 16'hFFFF);
    add_set(peak_set(1, 1, 32'h0000_FFFF));
    add_set(peak_set(1, 1, 32'h0001_0000));
    add_set(peak_set(32'h0001_0000, 0, '1));
    add_write(CFG_MASK, 16'h0000);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle();
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_set(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].result,
                 sender_gap());
      end
    end

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          write_register(CFG_FACTOR, FACTOR_RESET);
          write_register(CFG_MASK, '0);
          write_register(CFG_IGNORE_ALL, '0);
        end
        1: begin
          write_register(CFG_FACTOR, 16'd1);
          write_register(CFG_MASK, CFG_DATA_W'($urandom_range(0, 1023)));
          write_register(CFG_IGNORE_ALL, '0);
        end
        2: begin
          write_register(CFG_FACTOR, 16'hFFFF);
          write_register(CFG_MASK, 16'h03FF);
          write_register(CFG_IGNORE_ALL, '0);
        end
        3: begin
          write_register(CFG_FACTOR, 16'd0);
          write_register(CFG_MASK, CFG_DATA_W'($urandom_range(0, 1023)));
          write_register(CFG_IGNORE_ALL, '0);
        end
        4: begin
          write_register(CFG_FACTOR, CFG_DATA_W'($urandom_range(1, 65535)));
          write_register(CFG_MASK, CFG_DATA_W'($urandom_range(0, 1023)));
          write_register(CFG_IGNORE_ALL, 16'h0001);
        end
        default: begin
          write_register(CFG_FACTOR, CFG_DATA_W'($urandom_range(2, 1000)));
          write_register(CFG_MASK, '0);
          write_register(CFG_IGNORE_ALL, '0);
        end
      endcase
      steady_flow = (phase == 1);
      phase_sets  = (phase == IGNORE_PHASE) ? SHORT_PHASE_SETS : PHASE_SETS;
      for (int unsigned n = 0; n < phase_sets; n++) begin
        // The pressure phase keeps offering sets back to back while the
        // receiver holds off, so the block fills up and stalls its input.
        burst = (phase == PRESSURE_PHASE && n >= 20 && n < 60);
        if (phase == PRESSURE_PHASE && n == 20) long_hold_req <= 1'b1;
        if (n == 80) settle();
        send_set(random_set(), 1'b0, '0, burst ? 0 : sender_gap());
      end
    end

    steady_flow = 1'b0;
    settle();

    $display("Checked %0d power sets (%0d locked out) over %0d register writes; %0d hits seen.",
             sets_accepted, locked_sets, reg_writes, hits_seen);
    $display("Directed rows hit ties, lockouts, masks and threshold edges; random phases %s",
             "swept factors, masks and receiver stalls.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatching fields.", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mthd_pkg.sv
hdl/mthd_lane.sv
hdl/mthd_merge.sv
hdl/median_threshold_hit_detector.sv
bench/median_threshold_hit_detector_test.sv
